FILE: src/kdq_pkg.sv
package kdq_pkg;

    localparam int KEY_BITS    = 16;
    localparam int RECORD_BITS = 32;
    localparam int COUNT_BITS  = 5;

    localparam logic [2:0] CMD_PUSH_HEAD = 3'd0;
    localparam logic [2:0] CMD_PUSH_TAIL = 3'd1;
    localparam logic [2:0] CMD_POP_HEAD  = 3'd2;
    localparam logic [2:0] CMD_POP_TAIL  = 3'd3;
    localparam logic [2:0] CMD_SEARCH    = 3'd4;
    localparam logic [2:0] CMD_COUNT     = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0]             command;
        logic [KEY_BITS-1:0]    key;
        logic [RECORD_BITS-1:0] record;
    } t_in;

    typedef struct packed {
        logic [1:0]             status;
        logic [RECORD_BITS-1:0] record_out;
        logic [COUNT_BITS-1:0]  entry_count;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_CMP
    } t_state;

endpackage

FILE: src/kdq_store.sv
module kdq_store #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]            i_wr_addr,
    input  logic [kdq_pkg::KEY_BITS-1:0]        i_wr_key,
    input  logic [kdq_pkg::RECORD_BITS-1:0]     i_wr_record,
    input  logic [$clog2(DEPTH)-1:0]            i_rd_addr,
    output logic [kdq_pkg::KEY_BITS-1:0]        o_rd_key,
    output logic [kdq_pkg::RECORD_BITS-1:0]     o_rd_record
);

    logic [kdq_pkg::KEY_BITS-1:0]    r_keys    [DEPTH];
    logic [kdq_pkg::RECORD_BITS-1:0] r_records [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_keys[i_wr_addr]    <= i_wr_key;
            r_records[i_wr_addr] <= i_wr_record;
        end
        o_rd_key    <= r_keys[i_rd_addr];
        o_rd_record <= r_records[i_rd_addr];
    end

endmodule

FILE: src/keyed_deque_with_search_core.sv
// Push, count and failed commands finish in the execute state; pops go on through fetch and compare.
// A search passes through fetch and compare once per entry compared, for at most DEPTH entries.
// One item is in work at a time; busy is high until its result is strobed.
// The store's single read port and the one key comparator set the search rate.
// Synchronous active-low reset empties the list; the store itself is not cleared.
// Results are strobed for one cycle and the receiver cannot stall them.
module keyed_deque_with_search_core #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  kdq_pkg::t_in  i_item,
    output logic          o_strobe,
    output kdq_pkg::t_out o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    kdq_pkg::t_state r_state, n_state;
    kdq_pkg::t_in    r_item;
    kdq_pkg::t_out   r_result, n_result;
    logic            r_strobe, n_strobe;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [CW-1:0]   r_idx, n_idx;

    logic                               w_wr_en;
    logic [AW-1:0]                      w_wr_addr;
    logic [kdq_pkg::KEY_BITS-1:0]       w_rd_key;
    logic [kdq_pkg::RECORD_BITS-1:0]    w_rd_record;

    logic          w_full, w_empty, w_match, w_last;
    logic [AW-1:0] w_head_dec, w_ptr_inc, w_tail, w_back;
    logic [AW:0]   w_sum, w_sum_m1;
    logic [AW+5:0] w_cnt_wide;
    logic          w_finish;

    kdq_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_key   (r_item.key),
        .i_wr_record(r_item.record),
        .i_rd_addr  (r_ptr),
        .o_rd_key   (w_rd_key),
        .o_rd_record(w_rd_record)
    );

    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_match    = (w_rd_key == r_item.key);
    assign w_last     = ((r_idx + CW'(1)) == r_count);
    assign w_head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign w_ptr_inc  = (r_ptr == AW'(DEPTH - 1)) ? '0 : r_ptr + AW'(1);
    assign w_sum      = (AW + 1)'(r_head) + (AW + 1)'(r_count);
    assign w_sum_m1   = w_sum - (AW + 1)'(1);
    assign w_tail     = (w_sum >= (AW + 1)'(DEPTH)) ?
                        AW'(w_sum - (AW + 1)'(DEPTH)) : AW'(w_sum);
    assign w_back     = (w_sum_m1 >= (AW + 1)'(DEPTH)) ?
                        AW'(w_sum_m1 - (AW + 1)'(DEPTH)) : AW'(w_sum_m1);
    assign w_cnt_wide = (AW + 6)'(n_count);

    always_comb begin
        w_finish = 1'b0;
        case (r_state)
            kdq_pkg::S_EXEC: begin
                case (r_item.command)
                    kdq_pkg::CMD_POP_HEAD,
                    kdq_pkg::CMD_POP_TAIL,
                    kdq_pkg::CMD_SEARCH: w_finish = w_empty;
                    default:             w_finish = 1'b1;
                endcase
            end
            kdq_pkg::S_CMP: begin
                w_finish = (r_item.command != kdq_pkg::CMD_SEARCH) || w_match || w_last;
            end
            default: w_finish = 1'b0;
        endcase
    end

    always_comb begin
        case (r_state)
            kdq_pkg::S_IDLE:  n_state = start ? kdq_pkg::S_EXEC : kdq_pkg::S_IDLE;
            kdq_pkg::S_EXEC:  n_state = w_finish ? kdq_pkg::S_IDLE : kdq_pkg::S_FETCH;
            kdq_pkg::S_FETCH: n_state = kdq_pkg::S_CMP;
            kdq_pkg::S_CMP:   n_state = w_finish ? kdq_pkg::S_IDLE : kdq_pkg::S_FETCH;
            default:          n_state = kdq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_idx      = r_idx;
        w_wr_en    = 1'b0;
        w_wr_addr  = w_tail;
        n_strobe   = w_finish;
        n_result   = r_result;
        n_result.status     = kdq_pkg::ST_OK;
        n_result.record_out = '0;
        case (r_state)
            kdq_pkg::S_EXEC: begin
                case (r_item.command)
                    kdq_pkg::CMD_PUSH_HEAD: begin
                        if (w_full) begin
                            n_result.status = kdq_pkg::ST_FULL;
                        end else begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = w_head_dec;
                            n_head    = w_head_dec;
                            n_count   = r_count + CW'(1);
                        end
                    end
                    kdq_pkg::CMD_PUSH_TAIL: begin
                        if (w_full) begin
                            n_result.status = kdq_pkg::ST_FULL;
                        end else begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = w_tail;
                            n_count   = r_count + CW'(1);
                        end
                    end
                    kdq_pkg::CMD_POP_HEAD: begin
                        if (w_empty) begin
                            n_result.status = kdq_pkg::ST_EMPTY;
                        end else begin
                            n_ptr   = r_head;
                            n_head  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
                            n_count = r_count - CW'(1);
                        end
                    end
                    kdq_pkg::CMD_POP_TAIL: begin
                        if (w_empty) begin
                            n_result.status = kdq_pkg::ST_EMPTY;
                        end else begin
                            n_ptr   = w_back;
                            n_count = r_count - CW'(1);
                        end
                    end
                    kdq_pkg::CMD_SEARCH: begin
                        n_result.status = kdq_pkg::ST_NOT_FOUND;
                        n_ptr = r_head;
                        n_idx = '0;
                    end
                    default: begin
                    end
                endcase
            end
            kdq_pkg::S_CMP: begin
                if (r_item.command != kdq_pkg::CMD_SEARCH) begin
                    n_result.record_out = w_rd_record;
                end else if (w_match) begin
                    n_result.record_out = w_rd_record;
                end else begin
                    n_result.status = kdq_pkg::ST_NOT_FOUND;
                    n_ptr = w_ptr_inc;
                    n_idx = r_idx + CW'(1);
                end
            end
            default: begin
            end
        endcase
        n_result.entry_count = w_cnt_wide[kdq_pkg::COUNT_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kdq_pkg::S_IDLE;
            r_strobe <= 1'b0;
            r_head   <= '0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_head   <= n_head;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == kdq_pkg::S_IDLE) && start) begin
            r_item <= i_item;
        end
        r_ptr <= n_ptr;
        r_idx <= n_idx;
        if (w_finish) begin
            r_result <= n_result;
        end
    end

    assign busy     = (r_state != kdq_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
